### rtl/sdq_pkg.sv
// shared types, codes and defaults for the sorted deque
package sdq_pkg;

  // default sizes
  localparam int DEPTH_DEF     = 16;
  localparam int DATA_BITS_DEF = 32;

  // field widths of the request and result
  localparam int MODE_W   = 3;
  localparam int ITEM_W   = 32;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;
  localparam int RDATA_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCOUNT_W = 5;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((ITEM_W + KEY_W + POS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = MODE_W;
  localparam int OUT_TDATA_W = ((RDATA_W + STATUS_W + OCOUNT_W + 7) / 8) * 8;

  // request modes
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PEEK_POS   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd6;
  localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // per-cell update selector
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD  = 2'd0;
  localparam cell_op_t CELL_LOAD  = 2'd1;
  localparam cell_op_t CELL_LEFT  = 2'd2;
  localparam cell_op_t CELL_RIGHT = 2'd3;

endpackage

### rtl/sdq_cell.sv
// one storage cell of the deque row: data and key with neighbor shift
module sdq_cell #(
  parameter int DATA_BITS = sdq_pkg::DATA_BITS_DEF
) (
  input  logic                      clk,
  input  sdq_pkg::cell_op_t         op,
  input  logic [DATA_BITS-1:0]      new_data,
  input  logic [sdq_pkg::KEY_W-1:0] new_key,
  input  logic [DATA_BITS-1:0]      left_data,
  input  logic [sdq_pkg::KEY_W-1:0] left_key,
  input  logic [DATA_BITS-1:0]      right_data,
  input  logic [sdq_pkg::KEY_W-1:0] right_key,
  input  logic [sdq_pkg::KEY_W-1:0] cmp_key,
  output logic [DATA_BITS-1:0]      cell_data,
  output logic [sdq_pkg::KEY_W-1:0] cell_key,
  output logic                      key_ge
);
  import sdq_pkg::*;

  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;

  // pick the source for this cycle
  always_comb begin
    case (op)
      CELL_LOAD: begin
        data_nxt = new_data;
        key_nxt  = new_key;
      end
      CELL_LEFT: begin
        data_nxt = left_data;
        key_nxt  = left_key;
      end
      CELL_RIGHT: begin
        data_nxt = right_data;
        key_nxt  = right_key;
      end
      default: begin
        data_nxt = data_r;
        key_nxt  = key_r;
      end
    endcase
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    key_r  <= key_nxt;
  end

  // unsigned key compare for sorted insert
  assign key_ge    = (key_r >= cmp_key);
  assign cell_data = data_r;
  assign cell_key  = key_r;

endmodule

### rtl/sorted_deque_core.sv
// Sorted deque top level. Holds up to DEPTH entries (data word plus 32-bit key) in a row of cells,
// front in cell 0. Every request gets exactly one result: a push into a full store returns status
// full, a pop or front/back peek of an empty store or a peek past the count returns status empty,
// and result_data is zero whenever nothing is read. A request passes an accept and an apply state:
// in the accept cycle every cell compares its key and the read index is formed, both registered; in
// the apply state the row shifts or loads at once as the request needs and the result goes to the
// output register. The apply state waits while the output holds an unaccepted result, and no new
// request is taken until it is done. No clearing pass: the store is usable once reset is released.
module sorted_deque_core #(
  parameter int DEPTH     = sdq_pkg::DEPTH_DEF,
  parameter int DATA_BITS = sdq_pkg::DATA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // item_data [31:0], sort_key [63:32], position [67:64], zero pad above
  input  logic [sdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [2:0]
  input  logic [sdq_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result_data [31:0], status [33:32], entry_count [38:34], zero pad above
  output logic [sdq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sdq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // sequencer codes
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic                 state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [DATA_BITS-1:0] data_r;
  logic [KEY_W-1:0]     key_r;
  logic [DEPTH-1:0]     ins_r, ins_nxt;
  logic [IDX_W-1:0]     tgt_r, tgt_nxt;
  logic [STATUS_W-1:0]  stat_r, stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                 accept, commit;
  logic [MODE_W-1:0]    in_mode;
  logic [ITEM_W-1:0]    in_item;
  logic [KEY_W-1:0]     in_key;
  logic [POS_W-1:0]     in_pos;
  logic                 is_full, is_empty, pos_ok;
  logic                 is_push, is_pop;
  logic [DEPTH-1:0]     ge_vec;
  logic [DEPTH-1:0]     upto_ins;
  cell_op_t             cell_op [DEPTH];
  logic [DATA_BITS-1:0] cell_data [DEPTH];
  logic [KEY_W-1:0]     cell_key [DEPTH];
  logic [DATA_BITS-1:0] rd_data;
  logic [RDATA_W-1:0]   res_data;

  // request fields
  assign in_mode = in_tuser[MODE_W-1:0];
  assign in_item = in_tdata[ITEM_W-1:0];
  assign in_key  = in_tdata[ITEM_W+KEY_W-1:ITEM_W];
  assign in_pos  = in_tdata[ITEM_W+KEY_W+POS_W-1:ITEM_W+KEY_W];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign commit    = (state_r == ST_APPLY) && (!out_valid_r || out_tready);

  // occupancy checks against the current count
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign pos_ok   = (CMP_W'(in_pos) < CMP_W'(count_r));

  // insert position vector: lowest set bit marks the slot that takes the new entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      case (in_mode)
        MODE_PUSH_FRONT: ins_nxt[i] = 1'b1;
        MODE_INSERT:     ins_nxt[i] = ge_vec[i] || (CNT_W'(i) >= count_r);
        default:         ins_nxt[i] = (CNT_W'(i) >= count_r);
      endcase
    end
  end

  // status and read index of the request
  always_comb begin
    stat_nxt = STAT_OK;
    tgt_nxt  = '0;
    case (in_mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
        if (is_full) stat_nxt = STAT_FULL;
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (is_empty) stat_nxt = STAT_EMPTY;
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (is_empty) stat_nxt = STAT_EMPTY;
        else tgt_nxt = IDX_W'(count_r - CNT_W'(1));
      end
      MODE_PEEK_POS: begin
        if (!pos_ok) stat_nxt = STAT_EMPTY;
        else tgt_nxt = IDX_W'(in_pos);
      end
      default: stat_nxt = STAT_OK;
    endcase
  end

  // sequencer and request registers
  always_comb begin
    state_nxt = state_r;
    if (accept) state_nxt = ST_APPLY;
    else if (commit) state_nxt = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      data_r <= DATA_BITS'(in_item);
      key_r  <= in_key;
      ins_r  <= ins_nxt;
      tgt_r  <= tgt_nxt;
      stat_r <= stat_nxt;
    end
  end

  // request kind of the held request
  assign is_push = (stat_r == STAT_OK) &&
                   ((mode_r == MODE_PUSH_BACK) || (mode_r == MODE_PUSH_FRONT) ||
                    (mode_r == MODE_INSERT));
  assign is_pop  = (stat_r == STAT_OK) &&
                   ((mode_r == MODE_POP_FRONT) || (mode_r == MODE_POP_BACK));

  // ones from bit 0 up to and including the insert slot
  assign upto_ins = ins_r ^ (ins_r - {{(DEPTH-1){1'b0}}, 1'b1});

  // per-cell update selection
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (commit && is_push) begin
        if (!upto_ins[i]) cell_op[i] = CELL_LEFT;
        else if (ins_r[i]) cell_op[i] = CELL_LOAD;
      end else if (commit && is_pop && (mode_r == MODE_POP_FRONT)) begin
        cell_op[i] = CELL_RIGHT;
      end
    end
  end

  // row of cells, each fed by its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_BITS-1:0] l_data, r_data;
    logic [KEY_W-1:0]     l_key, r_key;
    if (g == 0) begin : g_first
      assign l_data = data_r;
      assign l_key  = key_r;
    end else begin : g_mid_l
      assign l_data = cell_data[g-1];
      assign l_key  = cell_key[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign r_data = cell_data[g];
      assign r_key  = cell_key[g];
    end else begin : g_mid_r
      assign r_data = cell_data[g+1];
      assign r_key  = cell_key[g+1];
    end
    sdq_cell #(.DATA_BITS(DATA_BITS)) u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .new_data   (data_r),
      .new_key    (key_r),
      .left_data  (l_data),
      .left_key   (l_key),
      .right_data (r_data),
      .right_key  (r_key),
      .cmp_key    (in_key),
      .cell_data  (cell_data[g]),
      .cell_key   (cell_key[g]),
      .key_ge     (ge_vec[g])
    );
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (commit && is_push) count_nxt = count_r + CNT_W'(1);
    else if (commit && is_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // read data for pops and peeks
  assign rd_data  = cell_data[tgt_r];
  assign res_data = ((stat_r == STAT_OK) && !is_push) ? RDATA_W'(rd_data) : '0;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({OCOUNT_W'(count_nxt), stat_r, res_data});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/sdq_checker.sv
// port-level checks for the sorted deque, bound to the top level
module sdq_checker #(
  parameter int DEPTH = sdq_pkg::DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [sdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [sdq_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sdq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sdq_pkg::*;

  logic [RDATA_W-1:0]  res_data;
  logic [STATUS_W-1:0] res_stat;
  logic [OCOUNT_W-1:0] res_count;
  logic                in_req;

  assign res_data  = out_tdata[RDATA_W-1:0];
  assign res_stat  = out_tdata[RDATA_W+STATUS_W-1:RDATA_W];
  assign res_count = out_tdata[RDATA_W+STATUS_W+OCOUNT_W-1:RDATA_W+STATUS_W];
  assign in_req    = in_tvalid && in_tready && (in_tdata != '1 || in_tuser != '1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: input closes right after a request
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a request");

  // a rejected push only when the store is full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_stat == STAT_FULL) |-> res_count == OCOUNT_W'(DEPTH))
    else $error("full status with store not full");

  // failed requests read no data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_stat != STAT_OK) |-> res_data == '0)
    else $error("data returned with a failing status");

  // a newly raised result has a status in range and does not follow straight on a taken request
  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> (res_stat != 2'd3) && !$past(in_req && in_tready))
    else $error("bad status or result too early");

endmodule

bind sorted_deque_core sdq_checker #(.DEPTH(DEPTH)) u_sdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sorted_deque_core_tb.sv
// testbench for the sorted deque: directed and random requests checked against a shadow store
`timescale 1ns / 100ps

module sorted_deque_core_tb;
  import sdq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IDLE_PCT = 19;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_NS = 400_000;

  // one result as the block reports it, lowest field last
  typedef struct packed {
    logic [OCOUNT_W-1:0] count;
    logic [STATUS_W-1:0] status;
    logic [RDATA_W-1:0]  rdata;
  } deque_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow copy of the store
  logic [ITEM_W-1:0] shadow_data [DEPTH];
  logic [KEY_W-1:0]  shadow_key [DEPTH];
  int                shadow_fill = 0;

  deque_result_t awaited_results [$];
  int            err_count = 0;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;

  sorted_deque_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("** sorted_deque_core: FAILED **");
    $finish;
  end

  // apply one request to the shadow store and return the result it should give
  function automatic deque_result_t apply_request(logic [MODE_W-1:0] mode,
                                                  logic [ITEM_W-1:0] d,
                                                  logic [KEY_W-1:0] k,
                                                  logic [POS_W-1:0] pos);
    deque_result_t r;
    int slot;
    int i;
    r.rdata = '0;
    r.status = STAT_OK;
    case (mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (mode == MODE_PUSH_BACK) begin
            slot = shadow_fill;
          end else if (mode == MODE_PUSH_FRONT) begin
            slot = 0;
          end else begin
            // ahead of the first entry whose key is greater or equal
            slot = 0;
            while (slot < shadow_fill && shadow_key[slot] < k) slot++;
          end
          for (i = shadow_fill; i > slot; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_key[i] = shadow_key[i-1];
          end
          shadow_data[slot] = d;
          shadow_key[slot] = k;
          shadow_fill++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else if (mode == MODE_POP_FRONT) begin
          r.rdata = shadow_data[0];
          for (i = 0; i + 1 < shadow_fill; i++) begin
            shadow_data[i] = shadow_data[i+1];
            shadow_key[i] = shadow_key[i+1];
          end
          shadow_fill--;
        end else begin
          r.rdata = shadow_data[shadow_fill-1];
          shadow_fill--;
        end
      end
      MODE_PEEK_POS: begin
        if (int'(pos) < shadow_fill) r.rdata = shadow_data[pos];
        else r.status = STAT_EMPTY;
      end
      default: begin
        if (shadow_fill == 0) r.status = STAT_EMPTY;
        else if (mode == MODE_PEEK_FRONT) r.rdata = shadow_data[0];
        else r.rdata = shadow_data[shadow_fill-1];
      end
    endcase
    r.count = shadow_fill[OCOUNT_W-1:0];
    return r;
  endfunction

  // offer one request and wait until the block takes it
  task automatic issue_request(logic [MODE_W-1:0] mode, logic [ITEM_W-1:0] d,
                               logic [KEY_W-1:0] k, logic [POS_W-1:0] pos);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {{(IN_TDATA_W-ITEM_W-KEY_W-POS_W){1'b0}}, pos, k, d};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_results.push_back(apply_request(mode, d, k, pos));
  endtask

  // stop offering and let every result come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keys drawn so that ties and the extremes come up often
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return KEY_W'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  // receiver side: random stalls, and a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each result with the oldest awaited one
  always @(posedge clk) begin : result_check
    deque_result_t want;
    deque_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[RDATA_W+STATUS_W+OCOUNT_W-1:0];
      if (awaited_results.size() == 0) begin
        $error("result with no request pending: %0h", got);
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got.rdata !== want.rdata) begin
          $error("result_data: expected %0h, got %0h", want.rdata, got.rdata);
          err_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
        if (got.count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, got.count);
          err_count++;
        end
      end
    end
  end

  // reads and pops of an empty store
  task automatic test_empty_store();
    issue_request(MODE_POP_FRONT, '1, '1, '0);
    issue_request(MODE_POP_BACK, '1, '1, '1);
    issue_request(MODE_PEEK_FRONT, '0, '0, '0);
    issue_request(MODE_PEEK_BACK, '0, '0, '1);
    issue_request(MODE_PEEK_POS, '0, '0, '0);
  endtask

  // fill up with every push mode, tied keys and extremes, then push into a full store
  task automatic test_fill_to_full();
    issue_request(MODE_PUSH_BACK, '1, '1, '0);
    issue_request(MODE_PUSH_FRONT, '0, '0, '0);
    issue_request(MODE_INSERT, 32'h0000_000a, 32'd5, '0);
    issue_request(MODE_INSERT, 32'h0000_000b, 32'd5, '0);
    issue_request(MODE_INSERT, 32'h5a5a_5a5a, '1, '0);
    issue_request(MODE_INSERT, 32'ha5a5_a5a5, '0, '0);
    while (shadow_fill < DEPTH)
      issue_request(MODE_W'($urandom_range(2)), $urandom, pick_key(), '0);
    issue_request(MODE_PUSH_BACK, '1, '1, '0);
    issue_request(MODE_PUSH_FRONT, '1, '1, '0);
    issue_request(MODE_INSERT, '1, '0, '0);
    // reads across the full row
    issue_request(MODE_PEEK_POS, '0, '0, 4'd15);
    issue_request(MODE_PEEK_POS, '0, '0, 4'd10);
    issue_request(MODE_PEEK_POS, '0, '0, 4'd5);
    issue_request(MODE_PEEK_FRONT, '0, '0, '0);
    issue_request(MODE_PEEK_BACK, '0, '0, '0);
  endtask

  // random requests, push_pct of them pushes of some kind
  task automatic test_random_mix(int n, int push_pct);
    logic [MODE_W-1:0] mode;
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct) mode = MODE_W'($urandom_range(2));
      else mode = MODE_W'($urandom_range(7, 3));
      issue_request(mode, $urandom, pick_key(), POS_W'($urandom_range(15)));
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random_mix(60, 50);
  endtask

  // a stretch with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_mix(250, 55);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_fill_to_full();
    test_random_mix(250, 25);
    test_random_mix(150, 50);
    test_random_mix(250, 75);
    test_random_mix(250, 25);
    test_full_rate();
    test_backpressure();
    test_random_mix(150, 50);
    drain_results();
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("** sorted_deque_core: PASSED **");
    end else begin
      $display("** sorted_deque_core: FAILED **");
    end
    $finish;
  end

endmodule
